[hw/rtl/gb5_pkg.sv]
// Shared types and constants of the 5x5 binomial RGB blur core.
// Used by gb5_linebuf, gb5_outq and gaussian_blur_5x5_rgb_core; depends on nothing.
`default_nettype none

package gb5_pkg;

    localparam int KSIZE = 5;
    localparam int NCH = 3;
    localparam int CHAN_W = 8;
    localparam int CFG_W = 12;
    localparam int IDX_W = 2;
    localparam int MAX_HEIGHT = 2048;
    localparam int H_W = 12;
    localparam int Y_W = 11;
    localparam int FRAME_WIDTH_RST = 640;
    localparam int FRAME_HEIGHT_RST = 480;

    localparam int VS_W = 12;
    localparam int HS_W = 15;
    localparam int PROD_W = 30;
    localparam int RECIP_SHIFT = 21;
    localparam logic [HS_W-1:0] RECIP = 15'd20972;
    localparam int QUO_W = 9;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    localparam int OUTQ_DEPTH = 8;
    localparam int OUTQ_PW = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW = $clog2(OUTQ_DEPTH + 1);

    localparam logic CMD_PIXEL = 1'b0;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef logic [NCH*CHAN_W-1:0] pixel_t;

    // Slot 0 holds the line above the current pixel, slot 3 the line four rows up.
    typedef pixel_t [KSIZE-2:0] entry_t;

    // Element 0 is the current pixel, element k the pixel k lines above it.
    typedef pixel_t [KSIZE-1:0] column_t;

    typedef struct packed {
        pixel_t pix;
        logic   frame_end;
    } result_t;

endpackage

`default_nettype wire

[hw/rtl/gb5_linebuf.sv]
// Four-line pixel history held as one column-indexed memory, updated read-modify-write.
// Depends on gb5_pkg for the pixel, entry and column types.
`default_nettype none

module gb5_linebuf #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          wr,
    input  wire [$clog2(MAX_WIDTH)-1:0]  addr,
    input  wire gb5_pkg::pixel_t         pix,
    output gb5_pkg::column_t             col
);

    localparam int XW = $clog2(MAX_WIDTH);

    gb5_pkg::entry_t mem [MAX_WIDTH];

    gb5_pkg::entry_t rdata_reg;
    gb5_pkg::entry_t fwd_data_reg;
    gb5_pkg::entry_t old_entry;
    gb5_pkg::entry_t wdata;
    gb5_pkg::pixel_t pix_reg;
    logic [XW-1:0]   addr_reg;
    logic            wr_reg;
    logic            fwd_reg;
    logic            fwd_next;

    // A write and a read of the same column at one edge returns stale data, so it is bypassed.
    assign fwd_next = wr_reg && (addr_reg == addr);
    assign old_entry = fwd_reg ? fwd_data_reg : rdata_reg;

    always_comb
    begin
        wdata[0] = pix_reg;
        for (int k = 1; k < gb5_pkg::KSIZE - 1; k++)
        begin
            wdata[k] = old_entry[k-1];
        end
        col[0] = pix_reg;
        for (int k = 1; k < gb5_pkg::KSIZE; k++)
        begin
            col[k] = old_entry[k-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            fwd_reg <= 1'b0;
        end
        else
        begin
            wr_reg  <= wr;
            fwd_reg <= fwd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg    <= mem[addr];
        addr_reg     <= addr;
        pix_reg      <= pix;
        fwd_data_reg <= wdata;
        if (wr_reg)
        begin
            mem[addr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gb5_outq.sv]
// Small result queue that decouples the arithmetic pipeline from the output stall.
// Depends on gb5_pkg for the result type and the queue depth.
`default_nettype none

module gb5_outq (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire                    push,
    input  wire gb5_pkg::result_t  push_data,
    input  wire                    pop,
    output logic                   valid,
    output gb5_pkg::result_t       head
);

    localparam int PW = gb5_pkg::OUTQ_PW;
    localparam int CW = gb5_pkg::OUTQ_CW;

    gb5_pkg::result_t q_reg [gb5_pkg::OUTQ_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_pop;

    assign valid  = (count_reg != '0);
    assign head   = q_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(gb5_pkg::OUTQ_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(gb5_pkg::OUTQ_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/gaussian_blur_5x5_rgb_core.sv]
// Streaming 5x5 binomial blur of RGB pixels; one item is taken every cycle while pix_stall is low.
// A result passes the s1, s2 and s3 stage registers and then the result queue before it is shown.
// The rate is set by the single read and write port of the column-indexed line memory.
// Results trail the input stream by two lines and two pixels; any items after the last pixel flush the rest.
// Reset clears all position counters and sets the frame to 640 by 480; no memory clearing pass.
// Depends on gb5_pkg, gb5_linebuf and gb5_outq.
`default_nettype none

module gaussian_blur_5x5_rgb_core #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          pix_valid,
    output logic                         pix_stall,
    input  wire                          cmd,
    input  wire [7:0]                    blue_in,
    input  wire [7:0]                    green_in,
    input  wire [7:0]                    red_in,
    output logic                         res_valid,
    input  wire                          res_stall,
    output logic [7:0]                   blue_out,
    output logic [7:0]                   green_out,
    output logic [7:0]                   red_out,
    output logic                         frame_end,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire [gb5_pkg::IDX_W-1:0]     cfg_index,
    input  wire [gb5_pkg::CFG_W-1:0]     cfg_data
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int LW = WW + 1;
    localparam int YW = gb5_pkg::Y_W;
    localparam int HW = gb5_pkg::H_W;
    localparam int CW = (WW > gb5_pkg::CFG_W) ? WW : gb5_pkg::CFG_W;
    localparam int W_RST = (gb5_pkg::FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH
                                                                   : gb5_pkg::FRAME_WIDTH_RST;
    localparam int NCH = gb5_pkg::NCH;
    localparam int KS = gb5_pkg::KSIZE;
    localparam int CHW = gb5_pkg::CHAN_W;

    typedef logic [gb5_pkg::VS_W-1:0] vsum_t;
    typedef logic [gb5_pkg::HS_W-1:0] hsum_t;

    typedef struct packed {
        logic       emit;
        logic       shift;
        logic       drain;
        logic       interior;
        logic       fend;
        logic [1:0] slot;
    } stage_ctl_t;

    function automatic vsum_t col_taps(input gb5_pkg::column_t c, input int ch);
        vsum_t a0;
        vsum_t a1;
        vsum_t a2;
        vsum_t a3;
        vsum_t a4;
        a0 = vsum_t'(c[0][CHW*ch +: CHW]);
        a1 = vsum_t'(c[1][CHW*ch +: CHW]);
        a2 = vsum_t'(c[2][CHW*ch +: CHW]);
        a3 = vsum_t'(c[3][CHW*ch +: CHW]);
        a4 = vsum_t'(c[4][CHW*ch +: CHW]);
        return a0 + (a1 << 1) + (a2 << 2) + (a3 << 1) + a4;
    endfunction

    function automatic hsum_t row_taps(input vsum_t v0, input vsum_t v1, input vsum_t v2,
                                       input vsum_t v3, input vsum_t v4);
        hsum_t b0;
        hsum_t b1;
        hsum_t b2;
        hsum_t b3;
        hsum_t b4;
        b0 = hsum_t'(v0);
        b1 = hsum_t'(v1);
        b2 = hsum_t'(v2);
        b3 = hsum_t'(v3);
        b4 = hsum_t'(v4);
        return b0 + (b1 << 1) + (b2 << 2) + (b3 << 1) + b4;
    endfunction

    // Frame geometry.
    logic [WW-1:0] w_reg;
    logic [WW-1:0] w_next;
    logic [HW-1:0] h_reg;
    logic [HW-1:0] h_next;
    logic [CW-1:0] cfg_ext;
    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;
    logic [WW-1:0] w_m1;
    logic [WW-1:0] w_m3;
    logic [HW-1:0] h_m1;
    logic [HW-1:0] h_m3;
    logic [XW-1:0] w_last;
    logic [XW-1:0] x_hi;
    logic [YW-1:0] h_last;
    logic [YW-1:0] y_hi;
    logic [LW-1:0] lag;
    logic          tiny_frame;

    // Stream position.
    logic [XW-1:0] in_x_reg;
    logic [XW-1:0] in_x_next;
    logic [YW-1:0] in_y_reg;
    logic [YW-1:0] in_y_next;
    logic          in_done_reg;
    logic          in_done_next;
    logic [XW-1:0] out_x_reg;
    logic [XW-1:0] out_x_next;
    logic [YW-1:0] out_y_reg;
    logic [YW-1:0] out_y_next;
    logic [LW-1:0] lead_reg;
    logic [LW-1:0] lead_next;

    logic          cfg_wr;
    logic          acc;
    logic          is_pix;
    logic          emit_pix;
    logic          emit;
    logic          o_end;
    logic          interior;
    logic [XW-1:0] rd_addr;
    logic [YW-1:0] slot_full;

    logic [gb5_pkg::OUTQ_CW-1:0] cred_reg;
    logic [gb5_pkg::OUTQ_CW-1:0] cred_next;
    logic                        res_take;

    stage_ctl_t s0_ctl;
    stage_ctl_t s1_ctl_reg;
    stage_ctl_t s2_ctl_reg;
    stage_ctl_t s3_ctl_reg;

    gb5_pkg::column_t col;
    gb5_pkg::pixel_t  drain_pix;
    gb5_pkg::pixel_t  s2_pix_reg;
    gb5_pkg::pixel_t  s3_pix_reg;
    gb5_pkg::pixel_t  ctr_reg [3];
    vsum_t            vs_reg [KS][NCH];
    hsum_t            s3_sum_reg [NCH];

    logic [gb5_pkg::PROD_W-1:0] prod [NCH];
    logic [gb5_pkg::QUO_W-1:0]  quo [NCH];
    gb5_pkg::pixel_t            blur_pix;
    gb5_pkg::result_t           res_in;
    gb5_pkg::result_t           res_head;

    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready &&
                    ((cfg_index == gb5_pkg::REG_FRAME_WIDTH) ||
                     (cfg_index == gb5_pkg::REG_FRAME_HEIGHT));

    assign cfg_ext = CW'(cfg_data);
    assign w_clamp = (cfg_data == '0) ? WW'(1) :
                     (cfg_ext > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_ext);
    assign h_clamp = (cfg_data == '0) ? HW'(1) :
                     (cfg_data > HW'(gb5_pkg::MAX_HEIGHT)) ? HW'(gb5_pkg::MAX_HEIGHT)
                                                          : cfg_data;

    assign w_m1   = w_reg - WW'(1);
    assign w_m3   = w_reg - WW'(3);
    assign h_m1   = h_reg - HW'(1);
    assign h_m3   = h_reg - HW'(3);
    assign w_last = w_m1[XW-1:0];
    assign x_hi   = w_m3[XW-1:0];
    assign h_last = h_m1[YW-1:0];
    assign y_hi   = h_m3[YW-1:0];
    assign lag    = LW'({w_reg, 1'b0}) + LW'(2);
    assign tiny_frame = (w_reg < WW'(5)) || (h_reg < HW'(5));

    assign acc      = pix_valid && !pix_stall;
    assign is_pix   = (cmd == gb5_pkg::CMD_PIXEL) && !in_done_reg;
    assign emit_pix = is_pix && (lead_reg >= lag);
    assign emit     = emit_pix || in_done_reg;
    assign o_end    = (out_x_reg == w_last) && (out_y_reg == h_last);
    assign interior = !tiny_frame && (out_y_reg >= YW'(2)) && (out_y_reg <= y_hi) &&
                      (out_x_reg >= XW'(2)) && (out_x_reg <= x_hi);
    assign rd_addr  = is_pix ? in_x_reg : out_x_reg;
    assign slot_full = h_last - out_y_reg;

    always_comb
    begin
        s0_ctl.emit     = acc && emit;
        s0_ctl.shift    = acc && is_pix;
        s0_ctl.drain    = in_done_reg;
        s0_ctl.interior = interior;
        s0_ctl.fend     = o_end;
        s0_ctl.slot     = slot_full[1:0];
    end

    always_comb
    begin
        w_next       = w_reg;
        h_next       = h_reg;
        in_x_next    = in_x_reg;
        in_y_next    = in_y_reg;
        in_done_next = in_done_reg;
        out_x_next   = out_x_reg;
        out_y_next   = out_y_reg;
        lead_next    = lead_reg;
        if (cfg_wr)
        begin
            if (cfg_index == gb5_pkg::REG_FRAME_WIDTH)
            begin
                w_next = w_clamp;
            end
            else
            begin
                h_next = h_clamp;
            end
            in_x_next    = '0;
            in_y_next    = '0;
            in_done_next = 1'b0;
            out_x_next   = '0;
            out_y_next   = '0;
            lead_next    = '0;
        end
        else if (acc)
        begin
            if (is_pix)
            begin
                if (in_x_reg == w_last)
                begin
                    in_x_next = '0;
                    if (in_y_reg == h_last)
                    begin
                        in_done_next = 1'b1;
                    end
                    else
                    begin
                        in_y_next = in_y_reg + YW'(1);
                    end
                end
                else
                begin
                    in_x_next = in_x_reg + XW'(1);
                end
                lead_next = emit_pix ? lead_reg : lead_reg + LW'(1);
            end
            if (emit)
            begin
                if (o_end)
                begin
                    in_x_next    = '0;
                    in_y_next    = '0;
                    in_done_next = 1'b0;
                    out_x_next   = '0;
                    out_y_next   = '0;
                    lead_next    = '0;
                end
                else if (out_x_reg == w_last)
                begin
                    out_x_next = '0;
                    out_y_next = out_y_reg + YW'(1);
                end
                else
                begin
                    out_x_next = out_x_reg + XW'(1);
                end
            end
        end
    end

    // Every result in flight holds a queue slot, so the pipeline itself never stalls.
    assign res_take = res_valid && !res_stall;

    always_comb
    begin
        unique case ({s0_ctl.emit, res_take})
            2'b10:   cred_next = cred_reg + gb5_pkg::OUTQ_CW'(1);
            2'b01:   cred_next = cred_reg - gb5_pkg::OUTQ_CW'(1);
            default: cred_next = cred_reg;
        endcase
    end

    assign pix_stall = (cred_reg == gb5_pkg::OUTQ_CW'(gb5_pkg::OUTQ_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= WW'(W_RST);
            h_reg       <= HW'(gb5_pkg::FRAME_HEIGHT_RST);
            in_x_reg    <= '0;
            in_y_reg    <= '0;
            in_done_reg <= 1'b0;
            out_x_reg   <= '0;
            out_y_reg   <= '0;
            lead_reg    <= '0;
            cred_reg    <= '0;
            s1_ctl_reg  <= '0;
            s2_ctl_reg  <= '0;
            s3_ctl_reg  <= '0;
        end
        else
        begin
            w_reg       <= w_next;
            h_reg       <= h_next;
            in_x_reg    <= in_x_next;
            in_y_reg    <= in_y_next;
            in_done_reg <= in_done_next;
            out_x_reg   <= out_x_next;
            out_y_reg   <= out_y_next;
            lead_reg    <= lead_next;
            cred_reg    <= cred_next;
            s1_ctl_reg  <= acc ? s0_ctl : '0;
            s2_ctl_reg  <= s1_ctl_reg;
            s3_ctl_reg  <= s2_ctl_reg;
        end
    end

    gb5_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (acc && is_pix),
        .addr  (rd_addr),
        .pix   ({red_in, green_in, blue_in}),
        .col   (col)
    );

    always_comb
    begin
        unique case (s1_ctl_reg.slot)
            2'd0:    drain_pix = col[1];
            2'd1:    drain_pix = col[2];
            2'd2:    drain_pix = col[3];
            default: drain_pix = col[4];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (s1_ctl_reg.shift)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                vs_reg[0][ch] <= col_taps(col, ch);
                for (int j = 1; j < KS; j++)
                begin
                    vs_reg[j][ch] <= vs_reg[j-1][ch];
                end
            end
            ctr_reg[0] <= col[2];
            ctr_reg[1] <= ctr_reg[0];
            ctr_reg[2] <= ctr_reg[1];
        end
        s2_pix_reg <= drain_pix;
        s3_pix_reg <= s2_ctl_reg.drain ? s2_pix_reg : ctr_reg[2];
        for (int ch = 0; ch < NCH; ch++)
        begin
            s3_sum_reg[ch] <= row_taps(vs_reg[0][ch], vs_reg[1][ch], vs_reg[2][ch],
                                       vs_reg[3][ch], vs_reg[4][ch]);
        end
    end

    // The quotient by the weight sum comes from a reciprocal multiply, exact for sums below 43690.
    always_comb
    begin
        for (int ch = 0; ch < NCH; ch++)
        begin
            prod[ch] = gb5_pkg::PROD_W'(s3_sum_reg[ch]) * gb5_pkg::PROD_W'(gb5_pkg::RECIP);
            quo[ch]  = prod[ch][gb5_pkg::RECIP_SHIFT +: gb5_pkg::QUO_W];
            blur_pix[CHW*ch +: CHW] = (quo[ch] > gb5_pkg::QUO_W'(gb5_pkg::CHAN_MAX))
                                      ? gb5_pkg::CHAN_MAX : quo[ch][CHW-1:0];
        end
    end

    always_comb
    begin
        res_in.pix       = s3_ctl_reg.interior ? blur_pix : s3_pix_reg;
        res_in.frame_end = s3_ctl_reg.fend;
    end

    gb5_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_ctl_reg.emit),
        .push_data (res_in),
        .pop       (!res_stall),
        .valid     (res_valid),
        .head      (res_head)
    );

    assign blue_out  = res_head.pix[7:0];
    assign green_out = res_head.pix[15:8];
    assign red_out   = res_head.pix[23:16];
    assign frame_end = res_head.frame_end;

    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cred_reg <= gb5_pkg::OUTQ_CW'(gb5_pkg::OUTQ_DEPTH))
        else $error("result credit count exceeds the queue depth");

    a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lead_reg <= lag)
        else $error("input lead over the output exceeds two lines and two pixels");

    a_drain_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_ctl_reg.drain && s1_ctl_reg.shift))
        else $error("a drain item updated the line memory");

    a_done_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        in_done_reg |-> (in_x_reg == '0))
        else $error("frame input finished away from the start of a line");

endmodule

`default_nettype wire

[sim/tb_gaussian_blur_5x5_rgb_core.sv]
// Self-checking testbench for gaussian_blur_5x5_rgb_core: random RGB frames in raster order,
// with drain items, register writes and random idling on both channels.
// Depends on gb5_pkg and the core RTL; predicts each blurred pixel from its own line history.
module tb_gaussian_blur_5x5_rgb_core;
    import gb5_pkg::*;

    localparam int MAX_W = 2048;
    localparam int LINE_DEPTH = 4 * MAX_W + 8;
    localparam int HALF = KSIZE / 2;
    localparam int WEIGHT_SUM = 100;
    localparam logic CMD_DRAIN = 1'b1;
    localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int QUIET_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 500;
    localparam int CLAMP_ITEMS = 40;

    typedef struct {
        logic       cmd;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_item_t;

    typedef struct {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       frame_end;
    } blur_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic pix_valid = 1'b0;
    logic pix_stall;
    logic cmd = CMD_PIXEL;
    logic [7:0] blue_in = 8'd0;
    logic [7:0] green_in = 8'd0;
    logic [7:0] red_in = 8'd0;
    logic res_valid;
    logic res_stall = 1'b0;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic frame_end;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
    logic [CFG_W-1:0] cfg_data = '0;

    pixel_item_t pending_items [$];
    blur_result_t expected_pixels [$];
    pixel_item_t next_item;

    pixel_t history_ring [LINE_DEPTH];
    int unsigned frame_width_reg = FRAME_WIDTH_RST;
    int unsigned frame_height_reg = FRAME_HEIGHT_RST;
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;
    int unsigned out_pos = 0;

    int items_queued = 0;
    int items_accepted = 0;
    int results_checked = 0;
    int frames_seen = 0;
    int register_writes = 0;
    int mismatches = 0;
    int send_gap = 0;
    int stall_left = 0;
    int quiet_cycles = 0;
    bit idle_on = 1'b0;

    gaussian_blur_5x5_rgb_core #(
        .MAX_WIDTH(MAX_W)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .pix_valid(pix_valid),
        .pix_stall(pix_stall),
        .cmd(cmd),
        .blue_in(blue_in),
        .green_in(green_in),
        .red_in(red_in),
        .res_valid(res_valid),
        .res_stall(res_stall),
        .blue_out(blue_out),
        .green_out(green_out),
        .red_out(red_out),
        .frame_end(frame_end),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int unsigned active_size(int unsigned value, int unsigned top);
        if (value < 1)
            return 1;
        if (value > top)
            return top;
        return value;
    endfunction

    function automatic int unsigned tap_weight(int k);
        if (k == HALF)
            return 4;
        if (k == HALF - 1 || k == HALF + 1)
            return 2;
        return 1;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] pick_channel();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return 8'd0;
        if (roll == 1)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int pick_dim();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            return 0;
        if (roll < 15)
            return KSIZE;
        if (roll < 75)
            return $urandom_range(1, 8);
        return $urandom_range(9, 20);
    endfunction

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        out_pos = 0;
    endtask

    task automatic emit_blurred(int unsigned w, int unsigned h);
        int unsigned y;
        int unsigned x;
        int unsigned q;
        int unsigned acc [3];
        pixel_t tap_pixel;
        pixel_t result_pixel;
        bit interior;
        blur_result_t res;
        y = out_pos / w;
        x = out_pos % w;
        interior = (w >= KSIZE) && (h >= KSIZE) && (y >= HALF) && (y + HALF < h) &&
                   (x >= HALF) && (x + HALF < w);
        if (interior)
        begin
            acc = '{0, 0, 0};
            for (int i = 0; i < KSIZE; i++)
            begin
                for (int j = 0; j < KSIZE; j++)
                begin
                    q = (y + i - HALF) * w + (x + j - HALF);
                    tap_pixel = history_ring[q % LINE_DEPTH];
                    for (int c = 0; c < NCH; c++)
                        acc[c] += tap_weight(i) * tap_weight(j) * tap_pixel[8*c +: 8];
                end
            end
            for (int c = 0; c < NCH; c++)
                result_pixel[8*c +: 8] = (acc[c] / WEIGHT_SUM > CHAN_MAX) ?
                                         CHAN_MAX : 8'(acc[c] / WEIGHT_SUM);
        end
        else
        begin
            result_pixel = history_ring[out_pos % LINE_DEPTH];
        end
        res.blue = result_pixel[7:0];
        res.green = result_pixel[15:8];
        res.red = result_pixel[23:16];
        res.frame_end = (out_pos + 1 == w * h);
        expected_pixels.push_back(res);
        out_pos++;
        if (out_pos >= w * h)
            restart_frame();
    endtask

    task automatic blur_step(pixel_item_t item);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned lag;
        int unsigned inpos;
        w = active_size(frame_width_reg, MAX_W);
        h = active_size(frame_height_reg, MAX_HEIGHT);
        total = w * h;
        lag = HALF * w + HALF;
        inpos = row_pos * w + col_pos;
        if (item.cmd == CMD_PIXEL && inpos < total)
        begin
            history_ring[inpos % LINE_DEPTH] = {item.red, item.green, item.blue};
            col_pos++;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (out_pos + lag <= inpos && out_pos < total)
                emit_blurred(w, h);
        end
        else if (inpos >= total && out_pos < total)
        begin
            emit_blurred(w, h);
        end
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_result();
        blur_result_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch($sformatf("result %h %h %h with no item pending",
                                      red_out, green_out, blue_out));
            return;
        end
        want = expected_pixels.pop_front();
        results_checked++;
        if (blue_out !== want.blue)
            report_mismatch($sformatf("blue_out %h, expected %h", blue_out, want.blue));
        if (green_out !== want.green)
            report_mismatch($sformatf("green_out %h, expected %h", green_out, want.green));
        if (red_out !== want.red)
            report_mismatch($sformatf("red_out %h, expected %h", red_out, want.red));
        if (frame_end !== want.frame_end)
            report_mismatch($sformatf("frame_end %b, expected %b", frame_end, want.frame_end));
        if (want.frame_end)
            frames_seen++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_valid && !pix_stall)
            begin
                blur_step('{cmd, blue_in, green_in, red_in});
                items_accepted++;
            end
            if (!pix_valid || !pix_stall)
            begin
                if (send_gap > 0 || pending_items.size() == 0)
                begin
                    if (send_gap > 0)
                        send_gap--;
                    pix_valid <= 1'b0;
                end
                else
                begin
                    next_item = pending_items.pop_front();
                    cmd <= next_item.cmd;
                    blue_in <= next_item.blue;
                    green_in <= next_item.green;
                    red_in <= next_item.red;
                    pix_valid <= 1'b1;
                    send_gap = idle_on ? pick_gap() : 0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                check_result();
            if (stall_left > 0)
            begin
                stall_left--;
                res_stall <= 1'b1;
            end
            else
            begin
                res_stall <= 1'b0;
                if (idle_on && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((pix_valid && !pix_stall) || (res_valid && !res_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("gaussian_blur_5x5_rgb_core verification failed");
                $finish;
            end
        end
    end

    task automatic queue_item(logic c, logic [7:0] b, logic [7:0] g, logic [7:0] r);
        pending_items.push_back('{c, b, g, r});
        items_queued++;
    endtask

    task automatic settle();
        while (items_accepted != items_queued || expected_pixels.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [IDX_W-1:0] idx, int value);
        settle();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(value);
        forever
        begin
            @(posedge clk);
            if (cfg_ready)
                break;
        end
        cfg_valid <= 1'b0;
        register_writes++;
        if (idx == REG_FRAME_WIDTH)
        begin
            frame_width_reg = value & 12'hFFF;
            restart_frame();
        end
        else if (idx == REG_FRAME_HEIGHT)
        begin
            frame_height_reg = value & 12'hFFF;
            restart_frame();
        end
    endtask

    task automatic queue_frame(int w, int h, bit broken);
        int total;
        int cut;
        int flush;
        total = w * h;
        cut = broken ? $urandom_range(0, total) : total;
        for (int p = 0; p < cut; p++)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_item(CMD_DRAIN, pick_channel(), pick_channel(), pick_channel());
            queue_item(broken ? 1'($urandom_range(0, 1)) : CMD_PIXEL,
                       pick_channel(), pick_channel(), pick_channel());
        end
        if (!broken)
        begin
            flush = (total < 2 * w + 2) ? total : 2 * w + 2;
            for (int k = 0; k < flush; k++)
                queue_item(($urandom_range(0, 3) == 0) ? CMD_PIXEL : CMD_DRAIN,
                           pick_channel(), pick_channel(), pick_channel());
            repeat ($urandom_range(0, 2))
                queue_item(CMD_DRAIN, pick_channel(), pick_channel(), pick_channel());
        end
    endtask

    initial
    begin
        int random_start;
        bit broken;
        bit prev_broken;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        write_register(REG_FRAME_WIDTH, 0);
        write_register(REG_FRAME_HEIGHT, 0);
        queue_item(CMD_PIXEL, 8'd255, 8'd0, 8'd255);
        queue_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_DRAIN, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_PIXEL, 8'd0, 8'd255, 8'd0);
        queue_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);

        write_register(REG_FRAME_WIDTH, 2);
        write_register(REG_FRAME_HEIGHT, 3);
        queue_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        queue_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255);
        queue_item(CMD_PIXEL, 8'd170, 8'd85, 8'd1);
        write_register(REG_SPARE_LO, 4095);
        write_register(REG_SPARE_HI, 0);
        queue_item(CMD_PIXEL, 8'd85, 8'd170, 8'd254);
        queue_item(CMD_PIXEL, 8'd255, 8'd0, 8'd128);
        queue_item(CMD_PIXEL, 8'd127, 8'd255, 8'd0);
        queue_item(CMD_PIXEL, 8'd9, 8'd9, 8'd9);
        repeat (5)
            queue_item(CMD_DRAIN, 8'd0, 8'd0, 8'd0);

        idle_on = 1'b1;
        write_register(REG_FRAME_WIDTH, 4095);
        write_register(REG_FRAME_HEIGHT, 4095);
        for (int p = 0; p < CLAMP_ITEMS; p++)
            queue_item(($urandom_range(0, 3) == 0) ? CMD_DRAIN : CMD_PIXEL,
                       pick_channel(), pick_channel(), pick_channel());

        random_start = items_queued;
        prev_broken = 1'b1;
        while (items_queued < random_start + RANDOM_ITEMS)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            broken = ($urandom_range(0, 5) == 0);
            if (prev_broken || $urandom_range(0, 2) != 0)
            begin
                write_register(REG_FRAME_WIDTH, pick_dim());
                write_register(REG_FRAME_HEIGHT, pick_dim());
                if ($urandom_range(0, 7) == 0)
                    write_register(REG_SPARE_HI, $urandom_range(0, 4095));
            end
            queue_frame(active_size(frame_width_reg, MAX_W),
                        active_size(frame_height_reg, MAX_HEIGHT), broken);
            prev_broken = broken;
        end

        settle();
        $display("Run covered %0d items and %0d register writes over %0d completed frames.",
                 items_accepted, register_writes, frames_seen);
        $display("%0d output pixels were checked, %0d mismatches found.",
                 results_checked, mismatches);
        if (mismatches == 0)
            $display("gaussian_blur_5x5_rgb_core verification clean");
        else
            $display("gaussian_blur_5x5_rgb_core verification failed");
        $finish;
    end

endmodule
